// ----- rtl/gbcs_pkg.sv -----
// shared types and constants of the grouped best candidate select block
package gbcs_pkg;

    localparam int MASS_W  = 20;
    localparam int SUM_W   = MASS_W + 1;
    localparam int RUN_W   = 32;
    localparam int EVENT_W = 64;
    localparam int ENTRY_W = 32;
    localparam int ID_W    = 8;

    localparam logic [MASS_W-1:0] TARGET_MASS_RESET = MASS_W'(5836);
    localparam logic [ID_W-1:0]   ID_ALL_TIGHT_ISO  = '1;

    // result buffer
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [RUN_W-1:0]   run_number;
        logic [EVENT_W-1:0] event_number;
        logic [ENTRY_W-1:0] entry_index;
        logic               passes_cut;
        logic [MASS_W-1:0]  pair12_mass;
        logic [MASS_W-1:0]  pair34_mass;
        logic [MASS_W-1:0]  lep1_pt;
        logic [MASS_W-1:0]  lep2_pt;
        logic [MASS_W-1:0]  lep3_pt;
        logic [MASS_W-1:0]  lep4_pt;
        logic [ID_W-1:0]    lepton_id_bits;
        logic               last_entry;
    } in_word_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] best_entry;
        logic               from_tight_class;
        logic               last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [MASS_W-1:0] distance;
        logic [SUM_W-1:0]  sum;
        logic              tight;
    } cand_t;

    typedef struct packed {
        logic               key_change;
        logic               pass;
        logic               last;
        cand_t              cand;
        logic [ENTRY_W-1:0] entry;
    } stage_t;

    typedef struct packed {
        logic               valid;
        logic [MASS_W-1:0]  distance;
        logic [SUM_W-1:0]   sum;
        logic [ENTRY_W-1:0] entry;
    } class_best_t;

endpackage

// ----- rtl/gbcs_metric.sv -----
// candidate metric: primary pair distance, tiebreak sum and tight class flag
module gbcs_metric
    import gbcs_pkg::*;
(
    input  in_word_t          word,
    input  logic [MASS_W-1:0] target_mass,
    output cand_t             cand
);

    logic [MASS_W-1:0] d12;
    logic [MASS_W-1:0] d34;
    logic [SUM_W-1:0]  sum12;
    logic [SUM_W-1:0]  sum34;

    always_comb begin
        d12 = (word.pair12_mass >= target_mass) ? word.pair12_mass - target_mass
                                                : target_mass - word.pair12_mass;
        d34 = (word.pair34_mass >= target_mass) ? word.pair34_mass - target_mass
                                                : target_mass - word.pair34_mass;
        sum12 = {1'b0, word.lep1_pt} + {1'b0, word.lep2_pt};
        sum34 = {1'b0, word.lep3_pt} + {1'b0, word.lep4_pt};
        // tie picks pair three-four
        if (d12 < d34) begin
            cand.distance = d12;
            cand.sum      = sum34;
        end else begin
            cand.distance = d34;
            cand.sum      = sum12;
        end
        cand.tight = (word.lepton_id_bits == ID_ALL_TIGHT_ISO);
    end

endmodule

// ----- rtl/grouped_best_candidate_select_core.sv -----
// top level: grouped best candidate select with input stage, class update and result buffer
// Takes one candidate word per cycle while the input is not stalled. At acceptance the key is compared
// with the previous word's key and the pair distance, tiebreak sum and class are worked out and
// registered in the input stage; from that stage the class bests are updated and up to two
// result words go into a four-word buffer. The input stalls only while that buffer holds
// more than two words, i.e. when the result side is held off.
module grouped_best_candidate_select_core
    import gbcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MASS_W-1:0] cfg_data
);

    logic [MASS_W-1:0]  target_mass_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [EVENT_W-1:0] event_reg;
    logic               p_valid_reg;
    logic               p_valid_next;
    stage_t             p_reg;
    class_best_t        tight_reg, tight_next;
    class_best_t        loose_reg, loose_next;
    out_word_t          fifo_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    cand_t       cand;
    logic        s_accept;
    logic        advance;
    logic        pop;
    class_best_t tight_a, loose_a, tight_b, loose_b;
    logic        r1_valid, r2_valid;
    out_word_t   r1_word, r2_word, w0, w1;
    logic [1:0]  push_cnt;

    gbcs_metric u_metric (
        .word        (s_data),
        .target_mass (target_mass_reg),
        .cand        (cand)
    );

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign advance   = p_valid_reg && (count_reg <= CNT_W'(OUT_DEPTH - 2));
    assign s_ready   = !p_valid_reg || advance;
    assign m_valid   = (count_reg != '0);
    assign m_data    = fifo_reg[rptr_reg];
    assign pop       = m_valid && m_ready;

    // class update and group close
    always_comb begin
        tight_a = p_reg.key_change ? '0 : tight_reg;
        loose_a = p_reg.key_change ? '0 : loose_reg;

        r1_valid = p_reg.key_change && (tight_reg.valid || loose_reg.valid);
        r1_word.best_entry       = tight_reg.valid ? tight_reg.entry : loose_reg.entry;
        r1_word.from_tight_class = tight_reg.valid;

        tight_b = tight_a;
        loose_b = loose_a;
        if (p_reg.pass) begin
            if (p_reg.cand.tight) begin
                if (!tight_a.valid || p_reg.cand.distance < tight_a.distance ||
                    (p_reg.cand.distance == tight_a.distance &&
                     p_reg.cand.sum > tight_a.sum)) begin
                    tight_b = {1'b1, p_reg.cand.distance, p_reg.cand.sum, p_reg.entry};
                end
            end else begin
                if (!loose_a.valid || p_reg.cand.distance < loose_a.distance ||
                    (p_reg.cand.distance == loose_a.distance &&
                     p_reg.cand.sum > loose_a.sum)) begin
                    loose_b = {1'b1, p_reg.cand.distance, p_reg.cand.sum, p_reg.entry};
                end
            end
        end

        r2_valid = p_reg.last && (tight_b.valid || loose_b.valid);
        r2_word.best_entry       = tight_b.valid ? tight_b.entry : loose_b.entry;
        r2_word.from_tight_class = tight_b.valid;
        r2_word.last_of_run      = 1'b1;
        r1_word.last_of_run      = !r2_valid;

        w0 = r1_valid ? r1_word : r2_word;
        w1 = r2_word;
        push_cnt = {1'b0, r1_valid} + {1'b0, r2_valid};
        if (!advance) begin
            push_cnt = 2'd0;
        end

        tight_next = tight_reg;
        loose_next = loose_reg;
        if (advance) begin
            tight_next = p_reg.last ? '0 : tight_b;
            loose_next = p_reg.last ? '0 : loose_b;
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        if (s_accept) begin
            p_valid_next = 1'b1;
        end else if (advance) begin
            p_valid_next = 1'b0;
        end
        wptr_next  = wptr_reg + PTR_W'(push_cnt);
        rptr_next  = rptr_reg + PTR_W'(pop);
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_mass_reg <= TARGET_MASS_RESET;
            run_reg         <= '0;
            event_reg       <= '0;
            p_valid_reg     <= 1'b0;
            tight_reg       <= '0;
            loose_reg       <= '0;
            wptr_reg        <= '0;
            rptr_reg        <= '0;
            count_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                target_mass_reg <= cfg_data;
            end
            if (s_accept) begin
                run_reg   <= s_data.run_number;
                event_reg <= s_data.event_number;
            end
            p_valid_reg <= p_valid_next;
            tight_reg   <= tight_next;
            loose_reg   <= loose_next;
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            count_reg   <= count_next;
        end
    end

    // input stage and result buffer payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_reg.key_change <= (s_data.run_number != run_reg) ||
                                (s_data.event_number != event_reg);
            p_reg.pass       <= s_data.passes_cut;
            p_reg.last       <= s_data.last_entry;
            p_reg.cand       <= cand;
            p_reg.entry      <= s_data.entry_index;
        end
        if (push_cnt != 2'd0) begin
            fifo_reg[wptr_reg] <= w0;
        end
        if (push_cnt == 2'd2) begin
            fifo_reg[PTR_W'(wptr_reg + 1'b1)] <= w1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(OUT_DEPTH))
        else $error("result buffer overfilled");

    a_double_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt == 2'd2) |-> (p_reg.key_change && p_reg.last))
        else $error("two results without key change and last entry");

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !m_data.last_of_run) |=> m_valid)
        else $error("first of a result pair not followed by its second word");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && p_reg.last) |=> (!tight_reg.valid && !loose_reg.valid))
        else $error("class bests survive a last entry");

endmodule

// ----- tb/tb_grouped_best_candidate_select_core.sv -----
// testbench for the grouped best candidate select core: directed and random traffic, running-best prediction
module tb_grouped_best_candidate_select_core;
    import gbcs_pkg::*;

    localparam logic [MASS_W-1:0] MASS_MAX = '1;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_word_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_word_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MASS_W-1:0] cfg_data  = '0;

    grouped_best_candidate_select_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    in_word_t          cand_q[$];
    out_word_t         best_q[$];
    bit                failed = 1'b0;
    int                in_count = 0;

    // predicted group state
    logic [MASS_W-1:0]  target_mass = TARGET_MASS_RESET;
    logic [RUN_W-1:0]   grp_run     = '0;
    logic [EVENT_W-1:0] grp_event   = '0;
    class_best_t        tight_best  = '0;
    class_best_t        loose_best  = '0;

    function automatic void queue_cand(input in_word_t w);
        cand_q.insert(cand_q.size(), w);
    endfunction

    function automatic bit close_group_pred(output out_word_t r);
        bit hit;
        hit = 1'b0;
        r = '0;
        if (tight_best.valid) begin
            r.best_entry = tight_best.entry;
            r.from_tight_class = 1'b1;
            hit = 1'b1;
        end else if (loose_best.valid) begin
            r.best_entry = loose_best.entry;
            hit = 1'b1;
        end
        tight_best = '0;
        loose_best = '0;
        return hit;
    endfunction

    function automatic void offer_best(inout class_best_t c, input logic [MASS_W-1:0] d,
                                       input logic [SUM_W-1:0] s,
                                       input logic [ENTRY_W-1:0] e);
        if (!c.valid || d < c.distance || (d == c.distance && s > c.sum)) begin
            c.valid    = 1'b1;
            c.distance = d;
            c.sum      = s;
            c.entry    = e;
        end
    endfunction

    task automatic predict_best(input in_word_t w);
        out_word_t         res[2];
        out_word_t         r;
        int                n;
        logic [MASS_W-1:0] d12;
        logic [MASS_W-1:0] d34;
        n = 0;
        if (w.run_number != grp_run || w.event_number != grp_event) begin
            if (close_group_pred(r)) begin
                res[n] = r;
                n++;
            end
        end
        grp_run   = w.run_number;
        grp_event = w.event_number;
        if (w.passes_cut) begin
            d12 = (w.pair12_mass >= target_mass) ? w.pair12_mass - target_mass
                                                 : target_mass - w.pair12_mass;
            d34 = (w.pair34_mass >= target_mass) ? w.pair34_mass - target_mass
                                                 : target_mass - w.pair34_mass;
            if (d12 < d34) begin
                if (w.lepton_id_bits == ID_ALL_TIGHT_ISO)
                    offer_best(tight_best, d12, SUM_W'(w.lep3_pt) + SUM_W'(w.lep4_pt),
                               w.entry_index);
                else
                    offer_best(loose_best, d12, SUM_W'(w.lep3_pt) + SUM_W'(w.lep4_pt),
                               w.entry_index);
            end else begin
                if (w.lepton_id_bits == ID_ALL_TIGHT_ISO)
                    offer_best(tight_best, d34, SUM_W'(w.lep1_pt) + SUM_W'(w.lep2_pt),
                               w.entry_index);
                else
                    offer_best(loose_best, d34, SUM_W'(w.lep1_pt) + SUM_W'(w.lep2_pt),
                               w.entry_index);
            end
        end
        if (w.last_entry) begin
            if (close_group_pred(r)) begin
                res[n] = r;
                n++;
            end
        end
        if (n > 0)
            res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            best_q.insert(best_q.size(), res[i]);
    endtask

    function automatic in_word_t cand(input logic [RUN_W-1:0] run,
                                      input logic [EVENT_W-1:0] evt,
                                      input logic [ENTRY_W-1:0] entry, input logic pass,
                                      input logic [MASS_W-1:0] m12, input logic [MASS_W-1:0] m34,
                                      input logic [MASS_W-1:0] p1, input logic [MASS_W-1:0] p2,
                                      input logic [MASS_W-1:0] p3, input logic [MASS_W-1:0] p4,
                                      input logic [ID_W-1:0] ids, input logic last);
        in_word_t w;
        w.run_number     = run;
        w.event_number   = evt;
        w.entry_index    = entry;
        w.passes_cut     = pass;
        w.pair12_mass    = m12;
        w.pair34_mass    = m34;
        w.lep1_pt        = p1;
        w.lep2_pt        = p2;
        w.lep3_pt        = p3;
        w.lep4_pt        = p4;
        w.lepton_id_bits = ids;
        w.last_entry     = last;
        return w;
    endfunction

    function automatic logic [MASS_W-1:0] near_target(input logic [MASS_W-1:0] t);
        int off;
        off = $urandom_range(0, 40);
        if ($urandom_range(0, 1) == 1 && int'(t) >= off)
            return t - MASS_W'(off);
        else if (int'(t) + off <= int'(MASS_MAX))
            return t + MASS_W'(off);
        else
            return t - MASS_W'(off);
    endfunction

    task automatic add_random(input int n, input logic [MASS_W-1:0] t);
        in_word_t           w;
        logic [RUN_W-1:0]   run;
        logic [EVENT_W-1:0] evt;
        int                 made;
        int                 sz;
        bit                 noise;
        made = 0;
        run  = '0;
        evt  = '0;
        while (made < n) begin
            noise = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    run = $urandom_range(0, 2);
                    evt = EVENT_W'($urandom_range(0, 3));
                end
                default: begin
                    run = $urandom;
                    evt = {$urandom, $urandom};
                end
            endcase
            sz = noise ? 1 : $urandom_range(1, 6);
            for (int i = 0; i < sz; i++) begin
                w.run_number     = noise ? RUN_W'($urandom) : run;
                w.event_number   = noise ? {$urandom, $urandom} : evt;
                w.entry_index    = $urandom;
                w.passes_cut     = noise ? 1'($urandom) : ($urandom_range(0, 4) != 0);
                w.pair12_mass    = MASS_W'($urandom);
                w.pair34_mass    = MASS_W'($urandom);
                w.lep1_pt        = MASS_W'($urandom);
                w.lep2_pt        = MASS_W'($urandom);
                w.lep3_pt        = MASS_W'($urandom);
                w.lep4_pt        = MASS_W'($urandom);
                w.lepton_id_bits = ID_W'($urandom);
                w.last_entry     = noise ? 1'($urandom) : 1'b0;
                if (!noise) begin
                    if ($urandom_range(0, 4) != 0) begin
                        w.pair12_mass = near_target(t);
                        w.pair34_mass = near_target(t);
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        w.lep1_pt = MASS_W'($urandom_range(0, 7));
                        w.lep2_pt = MASS_W'($urandom_range(0, 7));
                        w.lep3_pt = MASS_W'($urandom_range(0, 7));
                        w.lep4_pt = MASS_W'($urandom_range(0, 7));
                    end
                    if ($urandom_range(0, 1) == 1)
                        w.lepton_id_bits = ID_ALL_TIGHT_ISO;
                    else if ($urandom_range(0, 1) == 1)
                        w.lepton_id_bits = ~(ID_W'(1) << $urandom_range(0, ID_W - 1));
                    w.last_entry = (i == sz - 1) && ($urandom_range(0, 5) == 0);
                end
                queue_cand(w);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (cand_q.size() != 0 || s_valid || best_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_target(input logic [MASS_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid   <= 1'b0;
        target_mass = v;
    endtask

    // driver
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_best(s_data);
                in_count <= in_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (cand_q.size() > 0) begin
                    s_data  <= cand_q.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(5, 20);
                        endcase
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with long hold-offs to fill the result buffer
    int stall_mode   = 0;
    int mode_left    = 0;
    int hold_left    = 0;
    int next_hold_at = 150;

    always @(posedge aclk) begin : rx_ready
        logic rdy;
        rdy = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (in_count >= next_hold_at) begin
            hold_left    = 120;
            next_hold_at = next_hold_at + 270;
            rdy          = 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 150);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 3) != 0);
                default: rdy = ($urandom_range(0, 9) < 3);
            endcase
        end
        m_ready <= rdy;
    end

    // monitor
    always @(posedge aclk) begin : mon
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (best_q.size() == 0) begin
                $error("unexpected result word %h", m_data);
                failed = 1'b1;
            end else begin
                e = best_q.pop_front();
                if (m_data.best_entry !== e.best_entry) begin
                    $error("best_entry: expected %0h, got %0h", e.best_entry, m_data.best_entry);
                    failed = 1'b1;
                end
                if (m_data.from_tight_class !== e.from_tight_class) begin
                    $error("from_tight_class: expected %0b, got %0b",
                           e.from_tight_class, m_data.from_tight_class);
                    failed = 1'b1;
                end
                if (m_data.last_of_run !== e.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           e.last_of_run, m_data.last_of_run);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [MASS_W-1:0] t;
        logic [MASS_W-1:0] tm;
        tm = TARGET_MASS_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset target
        queue_cand(cand(0, 0, 0, 1, tm, MASS_W'(tm + 100), 0, 0, 0, 0, 8'h00, 0));
        queue_cand(cand(0, 0, 1, 1, 0, MASS_MAX, MASS_MAX, MASS_MAX, MASS_MAX, MASS_MAX,
                        ID_ALL_TIGHT_ISO, 0));
        queue_cand(cand(1, 0, 2, 0, tm, tm, 5, 5, 5, 5, ID_ALL_TIGHT_ISO, 0));
        queue_cand(cand(1, 0, 3, 0, tm, tm, 5, 5, 5, 5, 8'h00, 1));
        queue_cand(cand(1, 0, 4, 1, MASS_W'(tm - 5), MASS_W'(tm + 5), 100, 200, 1, 1,
                        8'h7F, 0));
        queue_cand(cand(1, 0, 5, 1, MASS_W'(tm + 5), MASS_W'(tm - 5), 100, 201, 1, 1,
                        8'hBF, 0));
        queue_cand(cand(1, 0, 6, 1, MASS_W'(tm - 5), MASS_W'(tm - 5), 150, 151, 9, 9,
                        8'h00, 0));
        queue_cand(cand(1, 0, 7, 1, MASS_W'(tm + 2), 0, 1, 1, 3, 4, 8'hFE, 0));
        queue_cand(cand('1, '1, '1, 1, tm, tm, 1, 2, 3, 4, ID_ALL_TIGHT_ISO, 1));
        queue_cand(cand('1, '1, 8, 1, tm, MASS_W'(tm + 1), 7, 7, 7, 7, ID_ALL_TIGHT_ISO, 0));
        queue_cand(cand(0, 1, 9, 1, MASS_W'(tm + 1), MASS_W'(tm + 3), 1, 1, 1, 1, 8'h55, 0));
        queue_cand(cand(1, 1, 10, 1, 1, 2, 1, 1, 1, 1, 8'hAA, 0));
        queue_cand(cand(1, 64'h8000_0000_0000_0000, 11, 1, MASS_MAX, MASS_MAX,
                        0, 0, 0, 0, 8'hFD, 0));
        queue_cand(cand(1, 64'h8000_0000_0000_0000, 12, 1, tm, tm,
                        2, 2, 2, 2, 8'hF7, 0));
        queue_cand(cand(0, 0, 13, 0, tm, tm, 1, 1, 1, 1, ID_ALL_TIGHT_ISO, 0));
        queue_cand(cand(0, 0, 14, 1, 0, 0, 3, 3, 3, 3, 8'hDF, 0));
        queue_cand(cand(0, 0, 15, 1, 0, 0, 3, 3, 3, 4, 8'hEF, 1));
        wait_idle();

        set_target('0);
        add_random(130, '0);
        wait_idle();

        set_target(MASS_MAX);
        add_random(130, MASS_MAX);
        wait_idle();

        t = MASS_W'($urandom_range(1, int'(MASS_MAX) - 1));
        set_target(t);
        add_random(150, t);
        wait_idle();

        set_target(TARGET_MASS_RESET);
        add_random(140, TARGET_MASS_RESET);
        wait_idle();

        if (failed)
            $display("FAILURE");
        else
            $display("SUCCESS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gbcs_pkg.sv
rtl/gbcs_metric.sv
rtl/grouped_best_candidate_select_core.sv
tb/tb_grouped_best_candidate_select_core.sv
